FILE: design/i2c_master_byte_sequencer_macros.svh
// Assertion macros for the I2C master byte sequencer.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH

// Property holds at every clock edge outside reset.
`define IMBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IMBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/imbs_pkg.sv
// Shared types and constants of the I2C master byte sequencer.
// No dependencies; imported by the controller, datapath and top level.
package imbs_pkg;

	localparam int PATTERN_MAX = 8;
	localparam logic [3:0] LEN_LIMIT = 4'((PATTERN_MAX < 8) ? PATTERN_MAX : 8);

	// command codes
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_SEND  = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;
	localparam logic [1:0] FUNC_STOP  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_SLAVE_ADDRESS = 3'd0;
	localparam logic [2:0] REG_START_PATTERN = 3'd1;
	localparam logic [2:0] REG_START_LENGTH  = 3'd2;
	localparam logic [2:0] REG_STOP_PATTERN  = 3'd3;
	localparam logic [2:0] REG_STOP_LENGTH   = 3'd4;

	// pin operations
	localparam logic [1:0] OP_SDA  = 2'd0;
	localparam logic [1:0] OP_SCL  = 2'd1;
	localparam logic [1:0] OP_DRV  = 2'd2;
	localparam logic [1:0] OP_HIGH = 2'd3;

	// symbols 0,1,0,0 and 1,1,1,0
	localparam logic [7:0] ACK_SEQ  = 8'h02;
	localparam logic [7:0] NACK_SEQ = 8'h07;
	localparam logic [2:0] ANSWER_LAST = 3'd3;

	typedef struct packed {
		logic [1:0] func;
		logic       write_mode;
		logic [7:0] data_byte;
		logic       ack_after_read;
		logic       slave_ack_level;
		logic [7:0] slave_byte;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       last;
		logic       acked;
		logic [7:0] read_data;
	} out_item_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		logic [1:0] op;
		logic       val;
		logic       last;
		logic       acked;
		logic       shift_pat;
		logic       shift_byte;
	} cmd_t;

	typedef struct packed {
		logic       op_ready;
		logic       pat_bit;
		logic       byte_msb;
		logic       nack;
		logic [1:0] func;
		logic [3:0] start_len;
		logic [3:0] stop_len;
	} sts_t;

	function automatic logic [3:0] clamp_len(input logic [3:0] len);
		clamp_len = (len > LEN_LIMIT) ? LEN_LIMIT : len;
	endfunction

endpackage

FILE: design/i2c_master_byte_sequencer.sv
// I2C master byte sequencer: one pin-operation beat per cycle while the output is taken.
// A command is accepted only when idle; its first beat follows via the state and result registers.
// Each command's pin operations come from the controller state machine, which emits one per cycle
// into the result register while the output register has room.
// Reset clears all config registers, sets SCL low, SDA low with SDA driven, and empties the output.
module i2c_master_byte_sequencer import imbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	cmd_t cmd;
	sts_t sts;

	imbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	imbs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: design/imbs_ctrl.sv
// Controller of the I2C master byte sequencer: walks each command through its pin operations.
// Depends on imbs_pkg and the assertion macro header.
`include "i2c_master_byte_sequencer_macros.svh"

module imbs_ctrl import imbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_func,
	output logic       in_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_PLAY     = 4'd1;
	localparam logic [3:0] ST_SDA      = 4'd2;
	localparam logic [3:0] ST_SCL_HI   = 4'd3;
	localparam logic [3:0] ST_SCL_LO   = 4'd4;
	localparam logic [3:0] ST_ACK_REL  = 4'd5;
	localparam logic [3:0] ST_ACK_HI   = 4'd6;
	localparam logic [3:0] ST_ACK_LO   = 4'd7;
	localparam logic [3:0] ST_ACK_DRV  = 4'd8;
	localparam logic [3:0] ST_NACK_HI  = 4'd9;
	localparam logic [3:0] ST_RD_REL   = 4'd10;
	localparam logic [3:0] ST_RD_HI    = 4'd11;
	localparam logic [3:0] ST_RD_LO    = 4'd12;
	localparam logic [3:0] ST_RD_DRV   = 4'd13;
	localparam logic [3:0] ST_STOP_END = 4'd14;

	localparam logic [2:0] BITS_LAST = 3'd7;

	logic [3:0] state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic       par_q, par_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		par_d   = par_q;
		cmd     = '0;
		cmd.load = in_valid && in_ready;
		cmd.emit = (state_q != ST_IDLE) && sts.op_ready;
		unique case (state_q)
			ST_IDLE: begin
				par_d = 1'b0;
				if (cmd.load) begin
					case (in_func)
						FUNC_START: begin
							if (sts.start_len == 4'd0) begin
								state_d = ST_SDA;
								cnt_d   = BITS_LAST;
							end else begin
								state_d = ST_PLAY;
								cnt_d   = 3'(sts.start_len - 4'd1);
							end
						end
						FUNC_SEND: begin
							state_d = ST_SDA;
							cnt_d   = BITS_LAST;
						end
						FUNC_READ: state_d = ST_RD_REL;
						default: begin
							if (sts.stop_len == 4'd0) begin
								state_d = ST_STOP_END;
							end else begin
								state_d = ST_PLAY;
								cnt_d   = 3'(sts.stop_len - 4'd1);
							end
						end
					endcase
				end
			end
			ST_PLAY: begin
				// even symbols drive SDA, odd symbols drive SCL
				cmd.op        = par_q ? OP_SCL : OP_SDA;
				cmd.val       = sts.pat_bit;
				cmd.shift_pat = cmd.emit;
				cmd.last      = (cnt_q == 3'd0) && (sts.func == FUNC_READ);
				if (cmd.emit) begin
					if (cnt_q != 3'd0) begin
						cnt_d = cnt_q - 3'd1;
						par_d = ~par_q;
					end else begin
						case (sts.func)
							FUNC_START: begin
								state_d = ST_SDA;
								cnt_d   = BITS_LAST;
							end
							FUNC_STOP: state_d = ST_STOP_END;
							default:   state_d = ST_IDLE;
						endcase
					end
				end
			end
			ST_SDA: begin
				cmd.op         = OP_SDA;
				cmd.val        = sts.byte_msb;
				cmd.shift_byte = cmd.emit;
				if (cmd.emit) state_d = ST_SCL_HI;
			end
			ST_SCL_HI: begin
				cmd.op  = OP_SCL;
				cmd.val = 1'b1;
				if (cmd.emit) state_d = ST_SCL_LO;
			end
			ST_SCL_LO: begin
				cmd.op  = OP_SCL;
				cmd.val = 1'b0;
				if (cmd.emit) begin
					if (cnt_q != 3'd0) begin
						cnt_d   = cnt_q - 3'd1;
						state_d = ST_SDA;
					end else begin
						state_d = ST_ACK_REL;
					end
				end
			end
			ST_ACK_REL: begin
				cmd.op  = OP_DRV;
				cmd.val = 1'b0;
				if (cmd.emit) state_d = ST_ACK_HI;
			end
			ST_ACK_HI: begin
				cmd.op  = OP_SCL;
				cmd.val = 1'b1;
				if (cmd.emit) state_d = ST_ACK_LO;
			end
			ST_ACK_LO: begin
				cmd.op  = OP_SCL;
				cmd.val = 1'b0;
				if (cmd.emit) state_d = ST_ACK_DRV;
			end
			ST_ACK_DRV: begin
				cmd.op    = OP_DRV;
				cmd.val   = 1'b1;
				cmd.last  = !sts.nack;
				cmd.acked = !sts.nack;
				if (cmd.emit) state_d = sts.nack ? ST_NACK_HI : ST_IDLE;
			end
			ST_NACK_HI: begin
				// release both lines together, report failure
				cmd.op   = OP_HIGH;
				cmd.val  = 1'b1;
				cmd.last = 1'b1;
				if (cmd.emit) state_d = ST_IDLE;
			end
			ST_RD_REL: begin
				cmd.op  = OP_DRV;
				cmd.val = 1'b0;
				if (cmd.emit) begin
					state_d = ST_RD_HI;
					cnt_d   = BITS_LAST;
				end
			end
			ST_RD_HI: begin
				cmd.op  = OP_SCL;
				cmd.val = 1'b1;
				if (cmd.emit) state_d = ST_RD_LO;
			end
			ST_RD_LO: begin
				cmd.op  = OP_SCL;
				cmd.val = 1'b0;
				if (cmd.emit) begin
					if (cnt_q != 3'd0) begin
						cnt_d   = cnt_q - 3'd1;
						state_d = ST_RD_HI;
					end else begin
						state_d = ST_RD_DRV;
					end
				end
			end
			ST_RD_DRV: begin
				cmd.op  = OP_DRV;
				cmd.val = 1'b1;
				if (cmd.emit) begin
					state_d = ST_PLAY;
					cnt_d   = ANSWER_LAST;
					par_d   = 1'b0;
				end
			end
			ST_STOP_END: begin
				cmd.op   = OP_HIGH;
				cmd.val  = 1'b1;
				cmd.last = 1'b1;
				if (cmd.emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 3'd0;
			par_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			par_q   <= par_d;
		end
	end

	`IMBS_ASSERT(a_no_emit_idle, !(state_q == ST_IDLE && cmd.emit), "pin op emitted while idle")
	`IMBS_ASSERT_NEXT(a_last_to_idle, cmd.emit && cmd.last, state_q == ST_IDLE, "command did not end after last beat")
	`IMBS_ASSERT(a_emit_needs_room, !cmd.emit || sts.op_ready, "pin op emitted into a full output register")

endmodule

FILE: design/imbs_datapath.sv
// Datapath of the I2C master byte sequencer: config registers, command operands,
// pin state and the result register. Depends on imbs_pkg and the assertion macro header.
`include "i2c_master_byte_sequencer_macros.svh"

module imbs_datapath import imbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  in_item_t   in_data,
	output out_item_t  out_data,
	output logic       out_valid,
	input  logic       out_ready,
	input  cmd_t       cmd,
	output sts_t       sts
);

	logic [6:0] slave_address_q;
	logic [7:0] start_pattern_q;
	logic [3:0] start_length_q;
	logic [7:0] stop_pattern_q;
	logic [3:0] stop_length_q;

	logic [1:0] func_q;
	logic [7:0] pat_q;
	logic [7:0] byte_q;
	logic       nack_q;
	logic [7:0] rdb_q;

	logic       scl_q, sda_q, drv_q;
	logic       scl_d, sda_d, drv_d;
	logic       out_valid_q;
	out_item_t  out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= '0;
			start_pattern_q <= '0;
			start_length_q  <= '0;
			stop_pattern_q  <= '0;
			stop_length_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SLAVE_ADDRESS: slave_address_q <= cfg_data[6:0];
				REG_START_PATTERN: start_pattern_q <= cfg_data;
				REG_START_LENGTH:  start_length_q  <= cfg_data[3:0];
				REG_STOP_PATTERN:  stop_pattern_q  <= cfg_data;
				REG_STOP_LENGTH:   stop_length_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// capture operands on accept, shift them as the controller consumes bits
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_data.func;
			nack_q <= in_data.slave_ack_level;
			rdb_q  <= in_data.slave_byte;
			byte_q <= (in_data.func == FUNC_START) ?
				{slave_address_q, ~in_data.write_mode} : in_data.data_byte;
			case (in_data.func)
				FUNC_READ: pat_q <= in_data.ack_after_read ? ACK_SEQ : NACK_SEQ;
				FUNC_STOP: pat_q <= stop_pattern_q;
				default:   pat_q <= start_pattern_q;
			endcase
		end else begin
			if (cmd.shift_pat)  pat_q  <= {1'b0, pat_q[7:1]};
			if (cmd.shift_byte) byte_q <= {byte_q[6:0], 1'b0};
		end
	end

	always_comb begin
		scl_d = scl_q;
		sda_d = sda_q;
		drv_d = drv_q;
		unique case (cmd.op)
			OP_SDA:  sda_d = cmd.val;
			OP_SCL:  scl_d = cmd.val;
			OP_DRV:  drv_d = cmd.val;
			OP_HIGH: begin
				scl_d = 1'b1;
				sda_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q       <= 1'b0;
			sda_q       <= 1'b0;
			drv_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			drv_q       <= drv_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.scl_level <= scl_d;
			out_q.sda_level <= sda_d;
			out_q.sda_drive <= drv_d;
			out_q.last      <= cmd.last;
			out_q.acked     <= cmd.acked;
			out_q.read_data <= (cmd.last && func_q == FUNC_READ) ? rdb_q : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.op_ready  = !out_valid_q || out_ready;
	assign sts.pat_bit   = pat_q[0];
	assign sts.byte_msb  = byte_q[7];
	assign sts.nack      = nack_q;
	assign sts.func      = func_q;
	assign sts.start_len = clamp_len(start_length_q);
	assign sts.stop_len  = clamp_len(stop_length_q);

	`IMBS_ASSERT(a_acked_on_last, !(out_valid_q && out_q.acked) || out_q.last, "acked set before the last beat")
	`IMBS_ASSERT(a_data_on_last, !(out_valid_q && out_q.read_data != 8'd0) || out_q.last, "read data set before the last beat")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for i2c_master_byte_sequencer: sends commands and register writes over
// valid/ready, predicts every pin-operation beat and checks them in order.
// Depends on imbs_pkg and the sequencer RTL only.
module tb;
	import imbs_pkg::*;

	localparam int RANDOM_ITEMS = 360;
	localparam int PHASES = 8;
	localparam int SETTLE_CYCLES = 40;
	// indexes with no register behind them
	localparam logic [2:0] REG_UNUSED_LO = 3'd5;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;

	// predicted register file and pin state
	logic [6:0] addr_reg;
	logic [7:0] start_pat_reg;
	logic [3:0] start_len_reg;
	logic [7:0] stop_pat_reg;
	logic [3:0] stop_len_reg;
	logic       line_scl;
	logic       line_sda;
	logic       line_oe;

	out_item_t  expected_pins[$];
	out_item_t  want_pins;
	int         fails = 0;
	int         idle_pct = 8;
	int         hold_off_len = 0;

	i2c_master_byte_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ---------------- pin predictor ----------------

	function automatic void record_pins();
		out_item_t beat;
		beat = '0;
		beat.scl_level = line_scl;
		beat.sda_level = line_sda;
		beat.sda_drive = line_oe;
		expected_pins.push_back(beat);
	endfunction

	function automatic void drive_scl(input logic v);
		line_scl = v;
		record_pins();
	endfunction

	function automatic void drive_sda(input logic v);
		line_sda = v;
		record_pins();
	endfunction

	function automatic void drive_oe(input logic v);
		line_oe = v;
		record_pins();
	endfunction

	// even symbols go to SDA, odd ones to SCL
	function automatic void play_symbols(input logic [7:0] pat, input logic [3:0] len,
			input int limit);
		int count;
		int i;
		count = len;
		if (count > limit)
			count = limit;
		if (count > 8)
			count = 8;
		for (i = 0; i < count; i++) begin
			if (i % 2 == 0)
				drive_sda(pat[i]);
			else
				drive_scl(pat[i]);
		end
	endfunction

	function automatic logic shift_out(input logic [7:0] octet, input logic nack);
		int i;
		for (i = 7; i >= 0; i--) begin
			drive_sda(octet[i]);
			drive_scl(1'b1);
			drive_scl(1'b0);
		end
		drive_oe(1'b0);
		drive_scl(1'b1);
		drive_scl(1'b0);
		drive_oe(1'b1);
		// release both lines high in a single operation on NACK
		if (nack) begin
			line_scl = 1'b1;
			line_sda = 1'b1;
			record_pins();
		end
		return !nack;
	endfunction

	function automatic void close_command(input logic ok, input logic [7:0] rdata);
		out_item_t beat;
		beat = expected_pins.pop_back();
		beat.last = 1'b1;
		beat.acked = ok;
		beat.read_data = rdata;
		expected_pins.push_back(beat);
	endfunction

	function automatic void predict_command(input in_item_t cmd);
		logic ok;
		int i;
		case (cmd.func)
		FUNC_START: begin
			play_symbols(start_pat_reg, start_len_reg, PATTERN_MAX);
			ok = shift_out({addr_reg, !cmd.write_mode}, cmd.slave_ack_level);
			close_command(ok, 8'h00);
		end
		FUNC_SEND: begin
			ok = shift_out(cmd.data_byte, cmd.slave_ack_level);
			close_command(ok, 8'h00);
		end
		FUNC_READ: begin
			drive_oe(1'b0);
			for (i = 0; i < 8; i++) begin
				drive_scl(1'b1);
				drive_scl(1'b0);
			end
			drive_oe(1'b1);
			play_symbols(cmd.ack_after_read ? ACK_SEQ : NACK_SEQ, 4'd4, 4);
			close_command(1'b0, cmd.slave_byte);
		end
		default: begin
			play_symbols(stop_pat_reg, stop_len_reg, PATTERN_MAX);
			line_scl = 1'b1;
			line_sda = 1'b1;
			record_pins();
			close_command(1'b0, 8'h00);
		end
		endcase
	endfunction

	function automatic void store_reg(input logic [2:0] idx, input logic [7:0] val);
		case (idx)
		REG_SLAVE_ADDRESS: addr_reg = val[6:0];
		REG_START_PATTERN: start_pat_reg = val;
		REG_START_LENGTH:  start_len_reg = val[3:0];
		REG_STOP_PATTERN:  stop_pat_reg = val;
		REG_STOP_LENGTH:   stop_len_reg = val[3:0];
		default: ;
		endcase
	endfunction

	// ---------------- result checking ----------------

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pins.size() == 0) begin
				fails++;
				$display("%0t ns: unexpected beat, expected none, actual %p",
					$time, out_data);
			end else begin
				want_pins = expected_pins.pop_front();
				compare_field("scl_level", want_pins.scl_level, out_data.scl_level);
				compare_field("sda_level", want_pins.sda_level, out_data.sda_level);
				compare_field("sda_drive", want_pins.sda_drive, out_data.sda_drive);
				compare_field("last", want_pins.last, out_data.last);
				compare_field("acked", want_pins.acked, out_data.acked);
				compare_field("read_data", want_pins.read_data, out_data.read_data);
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_len > 0) begin
				out_ready <= 1'b0;
				hold_off_len--;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// ---------------- bus tasks ----------------

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_cmd(input in_item_t cmd);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= cmd;
		do @(posedge clk); while (!in_ready);
		predict_command(cmd);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		store_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic load_config(input logic [7:0] addr, input logic [7:0] spat,
			input logic [7:0] slen, input logic [7:0] ppat, input logic [7:0] plen);
		write_reg(REG_SLAVE_ADDRESS, addr);
		write_reg(REG_START_PATTERN, spat);
		write_reg(REG_START_LENGTH, slen);
		write_reg(REG_STOP_PATTERN, ppat);
		write_reg(REG_STOP_LENGTH, plen);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait until every predicted beat has been seen
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic in_item_t make_cmd(input logic [1:0] func, input logic wr,
			input logic [7:0] octet, input logic ackr, input logic alev,
			input logic [7:0] sbyte);
		in_item_t cmd;
		cmd.func = func;
		cmd.write_mode = wr;
		cmd.data_byte = octet;
		cmd.ack_after_read = ackr;
		cmd.slave_ack_level = alev;
		cmd.slave_byte = sbyte;
		return cmd;
	endfunction

	function automatic in_item_t random_cmd(input logic [1:0] func);
		in_item_t cmd;
		cmd = in_item_t'($urandom);
		cmd.func = func;
		return cmd;
	endfunction

	task automatic load_random_config();
		logic [3:0] slen;
		logic [3:0] plen;
		// mostly legal lengths, now and then one that needs clamping
		slen = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
		plen = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
		load_config(8'($urandom), 8'($urandom), {4'($urandom), slen},
			8'($urandom), {4'($urandom), plen});
	endtask

	// well-formed transfers with random content, mixed with stray commands
	task automatic run_transfers(input int budget);
		int sent;
		int k;
		int j;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 15) begin
				send_cmd(random_cmd(2'($urandom_range(3))));
				sent++;
			end else begin
				send_cmd(random_cmd(FUNC_START));
				k = $urandom_range(4);
				for (j = 0; j < k; j++)
					send_cmd(random_cmd($urandom_range(1) ? FUNC_SEND : FUNC_READ));
				// leave some transfers without a stop
				if ($urandom_range(9) != 0)
					send_cmd(random_cmd(FUNC_STOP));
				sent += k + 2;
			end
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_reset_config();
		send_cmd(make_cmd(FUNC_START, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_SEND, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_SEND, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF));
		send_cmd(make_cmd(FUNC_READ, 1'b0, 8'h00, 1'b1, 1'b0, 8'hFF));
		send_cmd(make_cmd(FUNC_READ, 1'b1, 8'hFF, 1'b0, 1'b1, 8'h00));
		send_cmd(make_cmd(FUNC_STOP, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF));
		drain_results();
	endtask

	task automatic test_pattern_extremes();
		// full patterns, top address
		load_config(8'hFF, 8'hFF, 8'd8, 8'hFF, 8'd8);
		send_cmd(make_cmd(FUNC_START, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00));
		send_cmd(make_cmd(FUNC_SEND, 1'b0, 8'h80, 1'b0, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_READ, 1'b0, 8'h00, 1'b0, 1'b0, 8'hA5));
		send_cmd(make_cmd(FUNC_STOP, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
		drain_results();
		// oversize lengths clamp
		load_config(8'h00, 8'h00, 8'd15, 8'h00, 8'd15);
		send_cmd(make_cmd(FUNC_START, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_SEND, 1'b0, 8'h01, 1'b0, 1'b1, 8'h00));
		send_cmd(make_cmd(FUNC_STOP, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
		drain_results();
		// odd lengths, alternating symbols
		load_config(8'h2A, 8'hAA, 8'd9, 8'h55, 8'd1);
		send_cmd(make_cmd(FUNC_START, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_READ, 1'b0, 8'h00, 1'b1, 1'b0, 8'h5A));
		send_cmd(make_cmd(FUNC_STOP, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
		drain_results();
		// writes to unmapped indexes change nothing
		write_reg(REG_UNUSED_LO, 8'hFF);
		write_reg(REG_UNUSED_HI, 8'h00);
		cfg_valid <= 1'b0;
		send_cmd(make_cmd(FUNC_START, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
		send_cmd(make_cmd(FUNC_STOP, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
		drain_results();
	endtask

	task automatic test_backpressure();
		load_random_config();
		@(posedge clk);
		hold_off_len = 300;
		@(negedge clk);
		run_transfers(8);
		drain_results();
	endtask

	task automatic test_no_idle();
		idle_pct = 0;
		load_random_config();
		run_transfers(40);
		drain_results();
		idle_pct = 8;
	endtask

	task automatic test_random_traffic();
		int phase;
		for (phase = 0; phase < PHASES; phase++) begin
			load_random_config();
			run_transfers(RANDOM_ITEMS / PHASES);
			drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		addr_reg = '0;
		start_pat_reg = '0;
		start_len_reg = '0;
		stop_pat_reg = '0;
		stop_len_reg = '0;
		line_scl = 1'b0;
		line_sda = 1'b0;
		line_oe = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_config();
		test_pattern_extremes();
		test_backpressure();
		test_no_idle();
		test_random_traffic();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0 && expected_pins.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/imbs_pkg.sv
design/imbs_ctrl.sv
design/imbs_datapath.sv
design/i2c_master_byte_sequencer.sv
tb/tb.sv
